[sv/blp_pkg.sv]
`default_nettype none

package blp_pkg;

	// Field and state widths.
	localparam int unsigned LOAD_W  = 56;
	localparam int unsigned LINE_W  = 25;
	localparam int unsigned COUNT_W = 24;
	localparam int unsigned STEP_W  = 40;
	localparam int unsigned BLOCK_W = 8;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned CFG_W   = 40;
	localparam int unsigned IDX_W   = 2;

	// Result queue geometry.
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W     = 2;
	localparam int unsigned CNT_W     = 3;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_NUM_BLOCKS  = 2'd0;
	localparam logic [IDX_W-1:0] REG_TOTAL_LINES = 2'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_STEP = 2'd2;

	// Register reset values.
	localparam logic [BLOCK_W-1:0] NUM_BLOCKS_RST  = 8'd4;
	localparam logic [LINE_W-1:0]  TOTAL_LINES_RST = 25'd1;
	localparam logic [STEP_W-1:0]  TARGET_STEP_RST = 40'd256;
	localparam logic [LOAD_W-1:0]  TARGET_RST      = 56'd256;
	localparam logic [LOAD_W-1:0]  TARGET_NEXT_RST = 56'd512;
	localparam logic [LOAD_W-1:0]  LOAD_MAX        = {LOAD_W{1'b1}};
	localparam logic [LINE_W-1:0]  LINE_MAX        = {LINE_W{1'b1}};

	// One reported boundary.
	typedef struct packed {
		logic [BLOCK_W-1:0] block_index;
		logic [LINE_W-1:0]  boundary_line;
		logic               last_boundary;
	} result_t;

	// Saturating add of two load values.
	function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
		input logic [LOAD_W-1:0] b);
		logic [LOAD_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
	endfunction

	// Exact absolute difference of two load values.
	function automatic logic [LOAD_W-1:0] abs_diff(input logic [LOAD_W-1:0] a,
		input logic [LOAD_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

[sv/balanced_line_partitioner.sv]
// Balanced line partitioner.
// Lines arrive one per request on the input channel (in_valid/in_ready) with
// their entry count and a flag on the last line. Each line is compared against
// a rising cumulative target; a line that moves the load away from the target
// opens a new block and a boundary request goes out on the output channel
// (out_valid/out_ready). The closing boundary (total_lines, last_boundary set)
// follows after num_blocks-1 cuts or on the final line; later lines are taken
// and dropped until reset.
// Throughput: one line per cycle while the queue has room. A line is held in
// the input register, is evaluated by one add, two absolute differences and a
// compare, and its boundaries enter a four-entry result queue whose head is
// presented on the output channel. A line is evaluated only while the queue
// has room for two results, so when the receiver stalls the queue fills and
// in_ready drops; nothing is lost.
// Reset (arst_n low) restores the registers to num_blocks 4, total_lines 1,
// target_step 256, empties the queue and restarts the partition.
// Configuration writes (cfg_we, cfg_index, cfg_data) must only be issued
// while no line is in flight.
`default_nettype none

module balanced_line_partitioner (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write port.
	input  wire logic                               cfg_we,
	input  wire logic [blp_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [blp_pkg::CFG_W-1:0]          cfg_data,
	// Line input channel.
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [blp_pkg::COUNT_W-1:0]        line_count,
	input  wire logic                               final_line,
	// Boundary output channel.
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [blp_pkg::BLOCK_W-1:0]             block_index,
	output logic [blp_pkg::LINE_W-1:0]              boundary_line,
	output logic                                    last_boundary
);

	// Configuration registers.
	logic [blp_pkg::BLOCK_W-1:0] num_blocks_q;
	logic [blp_pkg::LINE_W-1:0]  total_lines_q;
	logic [blp_pkg::STEP_W-1:0]  target_step_q;

	// Partition state.
	logic [blp_pkg::LOAD_W-1:0]  running_q;
	logic [blp_pkg::LOAD_W-1:0]  target_q;
	logic [blp_pkg::LOAD_W-1:0]  target_next_q;
	logic [blp_pkg::LOAD_W-1:0]  best_q;
	logic [blp_pkg::BLOCK_W-1:0] block_q;
	logic [blp_pkg::LINE_W-1:0]  line_q;
	logic                        finished_q;

	// Input register.
	logic                         valid_s1;
	logic [blp_pkg::COUNT_W-1:0]  line_count_s1;
	logic                         final_line_s1;

	// Result queue.
	blp_pkg::result_t            res_q [blp_pkg::OUT_DEPTH];
	logic [blp_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [blp_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [blp_pkg::CNT_W-1:0]   cnt_q;

	// Evaluation signals.
	logic                        proc;
	logic                        active;
	logic                        pop;
	logic [blp_pkg::LOAD_W-1:0]  load_add;
	logic [blp_pkg::LOAD_W-1:0]  sum;
	logic [blp_pkg::LOAD_W-1:0]  dist_now;
	logic [blp_pkg::LOAD_W-1:0]  dist_next;
	logic [blp_pkg::LOAD_W-1:0]  step_ext;
	logic                        cut;
	logic                        close;
	logic [blp_pkg::BLOCK_W-1:0] block_new;
	logic [blp_pkg::BLOCK_W-1:0] nb_eff;
	logic [1:0]                  push_n;
	blp_pkg::result_t            cut_res;
	blp_pkg::result_t            close_res;
	blp_pkg::result_t            first_res;

	// Handshakes: a line is evaluated only when the queue has room for two results.
	assign proc     = valid_s1 && (cnt_q <= blp_pkg::CNT_W'(blp_pkg::OUT_DEPTH - 2));
	assign active   = proc && !finished_q;
	assign in_ready = !valid_s1 || proc;
	assign out_valid = (cnt_q != '0);
	assign pop      = out_valid && out_ready;

	// Output fields come from the head of the queue.
	assign block_index   = res_q[rd_ptr_q].block_index;
	assign boundary_line = res_q[rd_ptr_q].boundary_line;
	assign last_boundary = res_q[rd_ptr_q].last_boundary;

	// Load update and distance checks for the line in the input register.
	always_comb begin
		load_add  = {{(blp_pkg::LOAD_W - blp_pkg::COUNT_W - blp_pkg::FRAC_W){1'b0}},
			line_count_s1, {blp_pkg::FRAC_W{1'b0}}};
		step_ext  = {{(blp_pkg::LOAD_W - blp_pkg::STEP_W){1'b0}}, target_step_q};
		sum       = blp_pkg::sat_add(running_q, load_add);
		dist_now  = blp_pkg::abs_diff(sum, target_q);
		dist_next = blp_pkg::abs_diff(sum, target_next_q);
		cut       = dist_now > best_q;
		block_new = cut ? (block_q + 8'd1) : block_q;
		nb_eff    = (num_blocks_q == '0) ? 8'd1 : num_blocks_q;
		close     = (block_new >= nb_eff) || final_line_s1;

		cut_res.block_index     = block_q;
		cut_res.boundary_line   = line_q;
		cut_res.last_boundary   = 1'b0;
		close_res.block_index   = block_new;
		close_res.boundary_line = total_lines_q;
		close_res.last_boundary = 1'b1;
		first_res = cut ? cut_res : close_res;

		if (active) begin
			push_n = {1'b0, cut} + {1'b0, close};
		end else begin
			push_n = 2'd0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q  <= blp_pkg::NUM_BLOCKS_RST;
			total_lines_q <= blp_pkg::TOTAL_LINES_RST;
			target_step_q <= blp_pkg::TARGET_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				blp_pkg::REG_NUM_BLOCKS: begin
					num_blocks_q <= cfg_data[blp_pkg::BLOCK_W-1:0];
				end
				blp_pkg::REG_TOTAL_LINES: begin
					total_lines_q <= cfg_data[blp_pkg::LINE_W-1:0];
				end
				blp_pkg::REG_TARGET_STEP: begin
					target_step_q <= cfg_data[blp_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			line_count_s1 <= line_count;
			final_line_s1 <= final_line;
		end
	end

	// Partition state. The next target is kept ready one step ahead so that a
	// cut needs no add before the distance check; a new step refreshes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= '0;
			target_q      <= blp_pkg::TARGET_RST;
			target_next_q <= blp_pkg::TARGET_NEXT_RST;
			best_q        <= blp_pkg::LOAD_MAX;
			block_q       <= 8'd1;
			line_q        <= '0;
			finished_q    <= 1'b0;
		end else if (active) begin
			running_q <= sum;
			if (cut) begin
				target_q      <= target_next_q;
				target_next_q <= blp_pkg::sat_add(target_next_q, step_ext);
				best_q        <= dist_next;
			end else begin
				best_q <= dist_now;
			end
			block_q <= block_new;
			if (line_q != blp_pkg::LINE_MAX) begin
				line_q <= line_q + 25'd1;
			end
			if (close) begin
				finished_q <= 1'b1;
			end
		end else if (cfg_we && (cfg_index == blp_pkg::REG_TARGET_STEP)) begin
			target_next_q <= blp_pkg::sat_add(target_q,
				{{(blp_pkg::LOAD_W - blp_pkg::STEP_W){1'b0}},
				cfg_data[blp_pkg::STEP_W-1:0]});
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + blp_pkg::PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + blp_pkg::CNT_W'(push_n) - blp_pkg::CNT_W'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			res_q[wr_ptr_q] <= first_res;
		end
		if (push_n == 2'd2) begin
			res_q[wr_ptr_q + 2'd1] <= close_res;
		end
	end

`ifndef SYNTHESIS
	// The queue never holds more results than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= blp_pkg::CNT_W'(blp_pkg::OUT_DEPTH))
		else $error("result queue overfilled");

	// Once the partition is closed, no line produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (push_n == 2'd0))
		else $error("result produced after the closing boundary");

	// Queuing a closing boundary marks the partition as finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		(active && close) |=> finished_q)
		else $error("closing boundary did not finish the partition");

	// A stalled receiver sees the head result hold still.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(block_index)
		&& $stable(boundary_line) && $stable(last_boundary)))
		else $error("head result changed while stalled");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import blp_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_GAP   = 8;
	localparam int PHASE_LINES = 560;
	localparam int PHASE_CUTS  = 35;
	localparam int PLAN_LEN    = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic {ROW_LINE, ROW_WRITE} row_kind_t;

	// One step of the directed plan: a register write or a line request.
	typedef struct packed {
		row_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [CFG_W-1:0]   data;
		logic [COUNT_W-1:0] count;
		logic               fin;
		logic               typed;
		logic [1:0]         n_typed;
		result_t            first;
		result_t            second;
	} step_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [COUNT_W-1:0] line_count = '0;
	logic               final_line = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BLOCK_W-1:0] block_index;
	logic [LINE_W-1:0]  boundary_line;
	logic               last_boundary;

	balanced_line_partitioner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.line_count    (line_count),
		.final_line    (final_line),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.block_index   (block_index),
		.boundary_line (boundary_line),
		.last_boundary (last_boundary)
	);

	// Shadow registers and partition state of the predictor.
	logic [BLOCK_W-1:0] cfg_blocks = 8'd4;
	logic [LINE_W-1:0]  cfg_lines  = 25'd1;
	logic [STEP_W-1:0]  cfg_step   = 40'd256;
	logic [LOAD_W-1:0]  load_sum    = '0;
	logic [LOAD_W-1:0]  load_target = 56'd256;
	logic [LOAD_W-1:0]  best_gap    = '1;
	logic [BLOCK_W-1:0] blk_next    = 8'd1;
	logic [LINE_W-1:0]  line_no     = '0;
	logic               closed      = 1'b0;

	result_t boundary_q [$];
	int      err_cnt = 0;
	int      quiet_cycles = 0;
	int      idle_pct = 25;
	bit      hold_req = 1'b0;
	bit      hold_done = 1'b0;

	// Directed plan: reset settings first, then the field extremes.
	step_row_t plan [PLAN_LEN] = '{
		// Empty line: the load stays at zero, no cut.
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000000, 1'b0, 1'b1, 2'd0, '0, '0},
		// Load lands exactly on the first target.
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000001, 1'b0, 1'b1, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000000, 1'b0, 1'b1, 2'd0, '0, '0},
		// Passing the target opens block two at line 3.
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000001, 1'b0, 1'b1, 2'd1,
			'{8'd1, 25'd3, 1'b0}, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000000, 1'b0, 1'b1, 2'd0, '0, '0},
		// Largest count jumps far past the target.
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'hFFFFFF, 1'b0, 1'b1, 2'd1,
			'{8'd2, 25'd5, 1'b0}, '0},
		'{ROW_WRITE, REG_NUM_BLOCKS, 40'd255, '0, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_WRITE, REG_TARGET_STEP, 40'hFF_FFFF_FFFF, '0, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_WRITE, REG_TOTAL_LINES, 40'h100_0000, '0, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'hAAAAAA, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h555555, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'hFFFFFF, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000000, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000001, 1'b0, 1'b0, 2'd0, '0, '0},
		// A new step only counts from the next target rise.
		'{ROW_WRITE, REG_TARGET_STEP, 40'd256000, '0, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h123456, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'hFEDCBA, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h000001, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h800000, 1'b0, 1'b0, 2'd0, '0, '0},
		'{ROW_LINE, REG_NUM_BLOCKS, '0, 24'h7FFFFF, 1'b0, 1'b0, 2'd0, '0, '0}
	};

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Load arithmetic saturates at the top of the 56-bit range.
	function automatic logic [LOAD_W-1:0] load_add(input logic [LOAD_W-1:0] a,
		input logic [LOAD_W-1:0] b);
		logic [LOAD_W:0] wide;
		wide = {1'b0, a} + {1'b0, b};
		return wide[LOAD_W] ? {LOAD_W{1'b1}} : wide[LOAD_W-1:0];
	endfunction

	function automatic logic [LOAD_W-1:0] distance(input logic [LOAD_W-1:0] a,
		input logic [LOAD_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Advances the partition by one line and returns the boundaries it reports.
	task automatic partition_line(input logic [COUNT_W-1:0] cnt, input logic fin,
		output result_t res [2], output int n);
		logic [LOAD_W-1:0]  s;
		logic [LOAD_W-1:0]  gap;
		logic [BLOCK_W-1:0] eff_blocks;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (closed)
			return;
		eff_blocks = (cfg_blocks == 0) ? 8'd1 : cfg_blocks;
		s = load_add(load_sum, {{(LOAD_W-COUNT_W-8){1'b0}}, cnt, 8'h00});
		gap = distance(s, load_target);
		load_sum = s;
		if (gap <= best_gap) begin
			best_gap = gap;
		end else begin
			res[n] = '{blk_next, line_no, 1'b0};
			n++;
			blk_next = blk_next + 8'd1;
			load_target = load_add(load_target, {{(LOAD_W-STEP_W){1'b0}}, cfg_step});
			best_gap = distance(s, load_target);
		end
		if (line_no != {LINE_W{1'b1}})
			line_no = line_no + 25'd1;
		if (blk_next >= eff_blocks || fin) begin
			res[n] = '{blk_next, cfg_lines, 1'b1};
			n++;
			closed = 1'b1;
		end
	endtask

	function automatic logic [COUNT_W-1:0] rand_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COUNT_MAX;
			2, 3, 4: return COUNT_W'($urandom_range(0, 255));
			5, 6: return COUNT_W'($urandom_range(0, 65535));
			default: return COUNT_W'($urandom);
		endcase
	endfunction

	// Offers one line request and records what it should produce once accepted.
	// Called and returns at a falling edge.
	task automatic send_line(input logic [COUNT_W-1:0] cnt, input logic fin,
		input logic typed = 1'b0, input logic [1:0] n_typed = 2'd0,
		input result_t t0 = '0, input result_t t1 = '0);
		result_t due [2];
		int      n_due;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		line_count = cnt;
		final_line = fin;
		do @(posedge clk); while (!in_ready);
		partition_line(cnt, fin, due, n_due);
		if (typed) begin
			due[0] = t0;
			due[1] = t1;
			n_due = n_typed;
		end
		for (int j = 0; j < n_due; j++)
			boundary_q.push_back(due[j]);
		@(negedge clk);
	endtask

	// Lets the block run empty before a register write.
	task automatic settle();
		in_valid = 1'b0;
		while (boundary_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_NUM_BLOCKS:  cfg_blocks = data[BLOCK_W-1:0];
			REG_TOTAL_LINES: cfg_lines = data[LINE_W-1:0];
			REG_TARGET_STEP: cfg_step = data[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	// Receiver: short random stalls, and one long hold-off to fill the block.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready = 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Each boundary request is compared with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (boundary_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected boundary: index %0d line %0d last %0b",
					$time, block_index, boundary_line, last_boundary);
			end else begin
				want = boundary_q.pop_front();
				if (block_index !== want.block_index) begin
					err_cnt++;
					$display("%0t: block_index expected %0d actual %0d",
						$time, want.block_index, block_index);
				end
				if (boundary_line !== want.boundary_line) begin
					err_cnt++;
					$display("%0t: boundary_line expected %0d actual %0d",
						$time, want.boundary_line, boundary_line);
				end
				if (last_boundary !== want.last_boundary) begin
					err_cnt++;
					$display("%0t: last_boundary expected %0b actual %0b",
						$time, want.last_boundary, last_boundary);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int  cut_base;
		int  spins;
		int  close_mode;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed plan.
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_line(plan[i].count, plan[i].fin, plan[i].typed, plan[i].n_typed,
					plan[i].first, plan[i].second);
			end
		end

		// Random phases, each with its own step size; cuts are budgeted so the
		// partition stays open until the closing phase.
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			write_reg(REG_TOTAL_LINES, CFG_W'($urandom_range(1, 1 << 24)));
			case (ph)
				0: write_reg(REG_TARGET_STEP, {8'($urandom_range(2, 8)), 32'($urandom)});
				1: write_reg(REG_TARGET_STEP, 40'hFF_FFFF_FFFF);
				2: write_reg(REG_TARGET_STEP, {8'($urandom), 32'($urandom)});
				3: write_reg(REG_TARGET_STEP, CFG_W'($urandom_range(256, 1 << 20)));
				default: write_reg(REG_TARGET_STEP, {8'($urandom_range(1, 4)), 32'($urandom)});
			endcase
			write_reg(REG_NUM_BLOCKS, (ph == 2) ? 40'd250 : 40'd255);
			idle_pct = (ph == 2) ? 0 : 25;
			if (ph == 0)
				hold_req = 1'b1;
			cut_base = blk_next;
			for (int k = 0; k < PHASE_LINES && int'(blk_next) - cut_base < PHASE_CUTS; k++)
				send_line(rand_count(), 1'b0);
		end

		// Closing phase without idling: a zero step makes every further line a
		// cut, then the partition closes on a line that also cuts.
		settle();
		idle_pct = 0;
		write_reg(REG_TARGET_STEP, 40'd0);
		write_reg(REG_TOTAL_LINES, 40'h100_0000);
		cut_base = blk_next;
		spins = 0;
		while (int'(blk_next) - cut_base < 2 && spins < 700) begin
			send_line(COUNT_MAX, 1'b0);
			spins++;
		end
		settle();
		close_mode = $urandom_range(0, 2);
		case (close_mode)
			0: write_reg(REG_NUM_BLOCKS, 40'd0);
			1: write_reg(REG_NUM_BLOCKS, 40'd1);
			default: write_reg(REG_NUM_BLOCKS, 40'd255);
		endcase
		send_line(COUNT_MAX, close_mode == 2);

		// Lines after the close are taken and dropped.
		for (int k = 0; k < 6; k++)
			send_line(rand_count(), 1'($urandom_range(0, 1)));
		in_valid = 1'b0;

		while (boundary_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && boundary_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
